@@ hw/rtl/mdv_pkg.sv @@
`default_nettype none

package mdv_pkg;

  // descriptor characters
  localparam logic [7:0] CH_TERM   = 8'h00;
  localparam logic [7:0] CH_OPEN   = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE  = 8'h29;  // )
  localparam logic [7:0] CH_VOID   = 8'h56;  // V
  localparam logic [7:0] CH_ARRAY  = 8'h5B;  // [
  localparam logic [7:0] CH_CLASS  = 8'h4C;  // L
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
  localparam logic [7:0] CH_LONG   = 8'h4A;  // J
  localparam logic [7:0] CH_DOUBLE = 8'h44;  // D
  localparam logic [7:0] CH_BYTE   = 8'h42;  // B
  localparam logic [7:0] CH_CHAR   = 8'h43;  // C
  localparam logic [7:0] CH_FLOAT  = 8'h46;  // F
  localparam logic [7:0] CH_INT    = 8'h49;  // I
  localparam logic [7:0] CH_SHORT  = 8'h53;  // S
  localparam logic [7:0] CH_BOOL   = 8'h5A;  // Z

  // slot count saturation limit, bounded by the 8-bit result
  localparam int MAX_SLOTS = 255;
  localparam logic [7:0] SLOT_CAP = 8'((MAX_SLOTS < 255) ? MAX_SLOTS : 255);

  // parser phase
  typedef enum logic [2:0] {
    PH_OPEN    = 3'd0,
    PH_FIELD   = 3'd1,
    PH_ARRAY   = 3'd2,
    PH_CLASS   = 3'd3,
    PH_RETURN  = 3'd4,
    PH_AFTER_V = 3'd5
  } phase_t;

  // parser state carried from byte to byte
  typedef struct packed {
    phase_t     phase;
    logic       in_return;
    logic       failed;
    logic       decided_ok;
    logic [7:0] slot_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_OPEN,
    in_return:  1'b0,
    failed:     1'b0,
    decided_ok: 1'b0,
    slot_count: 8'd0
  };

  // result of a terminated descriptor
  typedef struct packed {
    logic       valid_res;
    logic [7:0] arg_slots;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/method_descriptor_validator_core.sv @@
`default_nettype none

// Method type descriptor checker. Descriptor bytes arrive on ch, one per
// transfer, and a zero byte ends the descriptor; only the zero byte yields a
// result transfer, carrying valid_res and the argument slot count (long and
// double take two slots, saturating at 255, zero for a bad descriptor). The
// block takes one byte every cycle while the input is not stalled: a byte is
// held in an input register, and when it advances the parser state is updated
// from it and, for a terminator, the result is loaded into the output
// register. The only stall on the input comes from a terminator that finds
// the output register full and stalled; a new descriptor may start right
// after a terminator.
module method_descriptor_validator_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] ch,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            valid_res,
  output logic [7:0]      arg_slots
);

  logic             full;
  logic [7:0]       ch_q;
  logic             advance;
  logic             out_free;
  logic             is_term;
  mdv_pkg::state_t  state;
  mdv_pkg::state_t  state_next;
  mdv_pkg::result_t res;

  // pipeline control
  assign is_term  = (ch_q == mdv_pkg::CH_TERM);
  assign out_free = !out_valid || !out_stall;
  assign advance  = full && (!is_term || out_free);
  assign in_stall = full && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_q <= ch;
    end
  end

  // parser transition
  mdv_step u_step (
    .ch  (ch_q),
    .cur (state),
    .nxt (state_next),
    .res (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdv_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_term) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_term) begin
      valid_res <= res.valid_res;
      arg_slots <= res.arg_slots;
    end
  end

  // a result only ever follows a processed terminator
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && is_term))
    else $error("result without terminator");

  // a bad descriptor reports no slots
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (arg_slots == 8'd0))
    else $error("slots reported for bad descriptor");

  // the parser starts afresh after every terminator
  assert property (@(posedge clk) disable iff (rst)
    (advance && is_term) |=> (state == mdv_pkg::STATE_RESET))
    else $error("state not cleared after terminator");

  // input stalls only behind a blocked result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (full && is_term && out_valid && out_stall))
    else $error("needless input stall");

endmodule

`default_nettype wire

@@ hw/rtl/mdv_step.sv @@
`default_nettype none

module mdv_step (
  input  wire logic [7:0]     ch,
  input  wire mdv_pkg::state_t cur,
  output mdv_pkg::state_t     nxt,
  output mdv_pkg::result_t    res
);

  logic       is_base;
  logic [1:0] slot_inc;
  logic [8:0] slot_sum;
  logic [7:0] slot_sat;
  logic       ok;

  // base type letters
  assign is_base = (ch == mdv_pkg::CH_BYTE)   || (ch == mdv_pkg::CH_CHAR)  ||
                   (ch == mdv_pkg::CH_DOUBLE) || (ch == mdv_pkg::CH_FLOAT) ||
                   (ch == mdv_pkg::CH_INT)    || (ch == mdv_pkg::CH_LONG)  ||
                   (ch == mdv_pkg::CH_SHORT)  || (ch == mdv_pkg::CH_BOOL);

  // saturating slot add, long and double take two
  assign slot_inc = ((ch == mdv_pkg::CH_LONG) || (ch == mdv_pkg::CH_DOUBLE)) ? 2'd2 : 2'd1;
  assign slot_sum = {1'b0, cur.slot_count} + {7'd0, slot_inc};
  assign slot_sat = (slot_sum > {1'b0, mdv_pkg::SLOT_CAP}) ? mdv_pkg::SLOT_CAP
                                                            : slot_sum[7:0];

  // next state
  always_comb begin
    nxt = cur;
    if (ch == mdv_pkg::CH_TERM) begin
      nxt = mdv_pkg::STATE_RESET;
    end else if (!cur.failed && !cur.decided_ok) begin
      unique case (cur.phase)
        mdv_pkg::PH_OPEN: begin
          if (ch == mdv_pkg::CH_OPEN) nxt.phase = mdv_pkg::PH_FIELD;
          else nxt.failed = 1'b1;
        end
        mdv_pkg::PH_FIELD: begin
          if (ch == mdv_pkg::CH_CLOSE) begin
            nxt.phase = mdv_pkg::PH_RETURN;
          end else begin
            nxt.slot_count = slot_sat;
            // argument types never sit in the return position
            if (ch == mdv_pkg::CH_ARRAY) nxt.phase = mdv_pkg::PH_ARRAY;
            else if (ch == mdv_pkg::CH_CLASS) nxt.phase = mdv_pkg::PH_CLASS;
            else if (is_base) nxt.phase = mdv_pkg::PH_FIELD;
            else nxt.failed = 1'b1;
          end
        end
        mdv_pkg::PH_ARRAY: begin
          if (ch == mdv_pkg::CH_ARRAY) begin
            nxt.phase = mdv_pkg::PH_ARRAY;
          end else if (ch == mdv_pkg::CH_CLASS) begin
            nxt.phase = mdv_pkg::PH_CLASS;
          end else if (is_base) begin
            if (cur.in_return) nxt.decided_ok = 1'b1;
            else nxt.phase = mdv_pkg::PH_FIELD;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        mdv_pkg::PH_CLASS: begin
          // class name runs up to the semicolon
          if (ch == mdv_pkg::CH_SEMI) begin
            if (cur.in_return) nxt.decided_ok = 1'b1;
            else nxt.phase = mdv_pkg::PH_FIELD;
          end
        end
        mdv_pkg::PH_RETURN: begin
          nxt.in_return = 1'b1;
          if (ch == mdv_pkg::CH_VOID) nxt.phase = mdv_pkg::PH_AFTER_V;
          else if (ch == mdv_pkg::CH_ARRAY) nxt.phase = mdv_pkg::PH_ARRAY;
          else if (ch == mdv_pkg::CH_CLASS) nxt.phase = mdv_pkg::PH_CLASS;
          else if (is_base) nxt.decided_ok = 1'b1;
          else nxt.failed = 1'b1;
        end
        default: begin
          // anything after void other than the terminator
          nxt.failed = 1'b1;
        end
      endcase
    end
  end

  // result for a terminator
  always_comb begin
    ok            = !cur.failed && (cur.decided_ok || (cur.phase == mdv_pkg::PH_AFTER_V));
    res.valid_res = ok;
    res.arg_slots = ok ? cur.slot_count : 8'd0;
  end

endmodule

`default_nettype wire
